FILE: hdl/image_line_skew_deskew_defines.svh
// assertion macros for the image line skew / deskew checker
// no dependencies; included by the files that carry assertions
`ifndef IMAGE_LINE_SKEW_DESKEW_DEFINES_SVH
`define IMAGE_LINE_SKEW_DESKEW_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define ILSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ILSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ilsd_pkg.sv
// shared types, constants and rounding helper for the line skew / deskew block
// no dependencies
package ilsd_pkg;

  localparam int PIXEL_BITS_DEF = 16;
  localparam int PIX_PORT_W     = 16;
  localparam int ACC_W          = 40;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NEGATIVE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_Q16      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_IN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT     = 3'd5;

  localparam logic [ACC_W-1:0] ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [ACC_W:0]   HALF_Q16 = 41'h8000;

  typedef struct packed {
    logic        forward_mode;
    logic        angle_negative;
    logic [23:0] slope_q16;
    logic [15:0] line_count;
    logic [15:0] samples_in;
    logic [7:0]  band_count;
  } ilsd_cfg_t;

  localparam ilsd_cfg_t CFG_RESET = '{
    forward_mode:   1'b1,
    angle_negative: 1'b0,
    slope_q16:      24'd0,
    line_count:     16'd1,
    samples_in:     16'd1,
    band_count:     8'd1
  };

  // stream position of one item, handed from the front stage to the shear stage
  typedef struct packed {
    logic             frame_start;
    logic             first_px;
    logic             last_band;
    logic             last_samp;
    logic             last_line;
    logic [15:0]      sample_idx;
    logic [ACC_W-1:0] prod;
  } ilsd_pos_t;

  // round half up from Q.16 to whole samples, saturating at 16 bits
  function automatic logic [15:0] round_q16(input logic [ACC_W-1:0] v);
    logic [ACC_W:0]    t;
    logic [ACC_W-16:0] r;
    t = {1'b0, v} + HALF_Q16;
    r = t[ACC_W:16];
    round_q16 = (|r[ACC_W-16:16]) ? 16'hFFFF : r[15:0];
  endfunction

endpackage

FILE: hdl/ilsd_front.sv
// input stage: item register, line/sample/band counters, frame-start product
// depends on ilsd_pkg
module ilsd_front import ilsd_pkg::*; #(
  parameter int PIX_W = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_PORT_W-1:0] pixel_in,
  input  ilsd_cfg_t             cfg,
  input  logic                  s2_ready,
  output logic                  s1_valid,
  output ilsd_pos_t             s1_pos,
  output logic [PIX_W-1:0]      s1_pix
);

  logic             s1_valid_r, s1_valid_nxt;
  ilsd_pos_t        s1_pos_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [15:0]      line_idx_r, line_idx_nxt;
  logic [15:0]      samp_idx_r, samp_idx_nxt;
  logic [7:0]       band_idx_r, band_idx_nxt;

  logic             in_acc, s1_go;
  logic             last_band, last_samp, last_line, frame_start;
  logic [15:0]      lc_m1;
  logic [ACC_W-1:0] prod_w;

  assign s1_go    = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;
  assign in_acc   = in_valid && !in_stall;

  assign last_band   = ({1'b0, band_idx_r} + 9'd1) >= {1'b0, cfg.band_count};
  assign last_samp   = ({1'b0, samp_idx_r} + 17'd1) >= {1'b0, cfg.samples_in};
  assign last_line   = ({1'b0, line_idx_r} + 17'd1) >= {1'b0, cfg.line_count};
  assign frame_start = (line_idx_r == 16'd0) && (samp_idx_r == 16'd0) && (band_idx_r == 8'd0);

  // a line count of zero acts as one
  assign lc_m1  = (cfg.line_count == 16'd0) ? 16'd0 : cfg.line_count - 16'd1;
  assign prod_w = {24'd0, lc_m1} * {16'd0, cfg.slope_q16};

  always_comb begin
    band_idx_nxt = band_idx_r;
    samp_idx_nxt = samp_idx_r;
    line_idx_nxt = line_idx_r;
    if (in_acc) begin
      if (!last_band) begin
        band_idx_nxt = band_idx_r + 8'd1;
      end else begin
        band_idx_nxt = 8'd0;
        if (!last_samp) begin
          samp_idx_nxt = samp_idx_r + 16'd1;
        end else begin
          samp_idx_nxt = 16'd0;
          line_idx_nxt = last_line ? 16'd0 : line_idx_r + 16'd1;
        end
      end
    end
  end

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      line_idx_r <= 16'd0;
      samp_idx_r <= 16'd0;
      band_idx_r <= 8'd0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      line_idx_r <= line_idx_nxt;
      samp_idx_r <= samp_idx_nxt;
      band_idx_r <= band_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r             <= pixel_in[PIX_W-1:0];
      s1_pos_r.frame_start <= frame_start;
      s1_pos_r.first_px    <= (samp_idx_r == 16'd0) && (band_idx_r == 8'd0);
      s1_pos_r.last_band   <= last_band;
      s1_pos_r.last_samp   <= last_samp;
      s1_pos_r.last_line   <= last_line;
      s1_pos_r.sample_idx  <= samp_idx_r;
      s1_pos_r.prod        <= prod_w;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_pos   = s1_pos_r;
  assign s1_pix   = s1_pix_r;

endmodule

FILE: hdl/ilsd_shear.sv
// shear stage: offset accumulator, padding counts or sample window, result register
// depends on ilsd_pkg
module ilsd_shear import ilsd_pkg::*; #(
  parameter int PIX_W = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ilsd_cfg_t             cfg,
  input  logic                  s1_valid,
  input  ilsd_pos_t             s1_pos,
  input  logic [PIX_W-1:0]      s1_pix,
  output logic                  s2_ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_PORT_W-1:0] pixel_out,
  output logic [15:0]           zeros_before,
  output logic [15:0]           zeros_after,
  output logic                  end_of_line,
  output logic                  end_of_frame
);

  logic                  out_valid_r;
  logic [PIX_PORT_W-1:0] pixel_r;
  logic [15:0]           zb_r, za_r;
  logic                  eol_r, eof_r;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [15:0]           ms_r, ms_nxt;

  logic             out_adv, go, emit, eol, line_end;
  logic [ACC_W-1:0] acc_item, acc_inc, acc_dec;
  logic [ACC_W:0]   acc_plus;
  logic [15:0]      ms_item, off_raw, offset, zb, za;
  logic [16:0]      width17, end17, samp17;
  logic             wide_ok, keep, eol_inv;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s2_ready = out_adv;
  assign go       = s1_valid && out_adv;

  // frame start reloads the maximum shift and the accumulator
  assign ms_item  = s1_pos.frame_start ? round_q16(s1_pos.prod) : ms_r;
  assign acc_item = s1_pos.frame_start ?
                    (cfg.angle_negative ? '0 : s1_pos.prod) : acc_r;
  assign off_raw  = round_q16(acc_item);
  assign offset   = (off_raw > ms_item) ? ms_item : off_raw;

  assign line_end = s1_pos.last_band && s1_pos.last_samp;

  // inverse window: samples offset .. offset+width-1
  assign samp17  = {1'b0, s1_pos.sample_idx};
  assign wide_ok = cfg.samples_in > ms_item;
  assign width17 = {1'b0, cfg.samples_in} - {1'b0, ms_item};
  assign end17   = {1'b0, offset} + width17;
  assign keep    = wide_ok && (samp17 >= {1'b0, offset}) && (samp17 < end17);
  assign eol_inv = (samp17 == end17 - 17'd1) && s1_pos.last_band;

  assign emit = cfg.forward_mode || keep;
  assign eol  = cfg.forward_mode ? line_end : eol_inv;
  assign zb   = (cfg.forward_mode && s1_pos.first_px) ? offset : 16'd0;
  assign za   = (cfg.forward_mode && line_end) ? (ms_item - offset) : 16'd0;

  // saturating step of the accumulator at each line end but the last line's
  assign acc_plus = {1'b0, acc_item} + {17'd0, cfg.slope_q16};
  assign acc_inc  = acc_plus[ACC_W] ? ACC_MAX : acc_plus[ACC_W-1:0];
  assign acc_dec  = (acc_item >= {16'd0, cfg.slope_q16}) ?
                    acc_item - {16'd0, cfg.slope_q16} : '0;

  always_comb begin
    acc_nxt = acc_r;
    ms_nxt  = ms_r;
    if (go) begin
      ms_nxt = ms_item;
      if (line_end && !s1_pos.last_line) begin
        acc_nxt = cfg.angle_negative ? acc_inc : acc_dec;
      end else begin
        acc_nxt = acc_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      ms_r        <= 16'd0;
    end else begin
      acc_r <= acc_nxt;
      ms_r  <= ms_nxt;
      if (out_adv) begin
        out_valid_r <= go && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      pixel_r <= PIX_PORT_W'(s1_pix);
      zb_r    <= zb;
      za_r    <= za;
      eol_r   <= eol;
      eof_r   <= eol && s1_pos.last_line;
    end
  end

  assign out_valid    = out_valid_r;
  assign pixel_out    = pixel_r;
  assign zeros_before = zb_r;
  assign zeros_after  = za_r;
  assign end_of_line  = eol_r;
  assign end_of_frame = eof_r;

endmodule

FILE: hdl/image_line_skew_deskew.sv
// top level of the horizontal image shear (line skew / deskew) block
// depends on ilsd_pkg, ilsd_front and ilsd_shear
//
// Takes one band-interleaved pixel per cycle while in_stall is low and gives
// at most one result per pixel. The result passes through the input register
// and then the result register before it reaches the result ports. With
// out_stall low the block sustains one item per cycle. The rate is set by the
// two-stage pipeline: an input register (counters and the 16x24 frame-start
// product) and a result register (offset rounding, clamping and padding or
// window logic). The running offset accumulator lives in the second stage and
// steps once per line, so back-to-back items see it without a bubble. in_stall
// rises only when both stages hold an item and the result is stalled. Forward
// mode passes every pixel and reports the left and right zero padding, in
// samples, on the first and last pixel of each line; inverse mode keeps the
// window of samples_in minus the frame's maximum shift samples, starting at
// the line's offset, and drops the rest. The user must write registers through
// the cfg port (always ready) only while the stream is idle; the block itself
// does not enforce it. There is no clearing pass after reset.
module image_line_skew_deskew import ilsd_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_PORT_W-1:0] pixel_in,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_PORT_W-1:0] pixel_out,
  output logic [15:0]           zeros_before,
  output logic [15:0]           zeros_after,
  output logic                  end_of_line,
  output logic                  end_of_frame,
  // register write port
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // pixels are kept only as wide as the port or PIXEL_BITS, whichever is less
  localparam int PIX_W = (PIXEL_BITS < PIX_PORT_W) ? PIXEL_BITS : PIX_PORT_W;

  ilsd_cfg_t        cfg_r, cfg_nxt;
  logic             s1_valid, s2_ready;
  ilsd_pos_t        s1_pos;
  logic [PIX_W-1:0] s1_pix;

  // register port never back-pressures
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FORWARD_MODE:   cfg_nxt.forward_mode   = cfg_data[0];
        REG_ANGLE_NEGATIVE: cfg_nxt.angle_negative = cfg_data[0];
        REG_SLOPE_Q16:      cfg_nxt.slope_q16      = cfg_data[23:0];
        REG_LINE_COUNT:     cfg_nxt.line_count     = cfg_data[15:0];
        REG_SAMPLES_IN:     cfg_nxt.samples_in     = cfg_data[15:0];
        REG_BAND_COUNT:     cfg_nxt.band_count     = cfg_data[7:0];
        default:            cfg_nxt = cfg_r;  // unused index, write ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // stage one: counters, frame-start product, item register
  ilsd_front #(
    .PIX_W (PIX_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pixel_in (pixel_in),
    .cfg      (cfg_r),
    .s2_ready (s2_ready),
    .s1_valid (s1_valid),
    .s1_pos   (s1_pos),
    .s1_pix   (s1_pix)
  );

  // stage two: offset and padding, result register
  ilsd_shear #(
    .PIX_W (PIX_W)
  ) u_shear (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .s1_valid     (s1_valid),
    .s1_pos       (s1_pos),
    .s1_pix       (s1_pix),
    .s2_ready     (s2_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_out    (pixel_out),
    .zeros_before (zeros_before),
    .zeros_after  (zeros_after),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame)
  );

endmodule

FILE: hdl/ilsd_checker.sv
// port-level assertions for the line skew / deskew block, bound to the top level
// depends on ilsd_pkg and image_line_skew_deskew_defines.svh
`include "image_line_skew_deskew_defines.svh"

module ilsd_checker import ilsd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [PIX_PORT_W-1:0] pixel_out,
  input logic [15:0]           zeros_after,
  input logic                  end_of_line,
  input logic                  end_of_frame
);

  // a stalled result holds
  `ILSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_out) && $stable(end_of_line), "stalled result changed")

  // input back-pressure only comes from a stalled result
  `ILSD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output stall")

  // right padding is only reported on the last pixel of a line
  `ILSD_ASSERT_NOW(a_pad_eol, out_valid && zeros_after != 16'd0, end_of_line, "zeros_after off line end")

  // frame end is always a line end
  `ILSD_ASSERT_NOW(a_eof_eol, out_valid && end_of_frame, end_of_line, "end_of_frame without end_of_line")

endmodule

bind image_line_skew_deskew ilsd_checker u_ilsd_checker (.*);
